[sv/klf_pkg.sv]
// Package for the keyword line filter.
// Holds the keyword tables, the window type and the case-folding function.
// Has no dependencies; the files that use it do so by scoped names.
package klf_pkg;

   localparam int MAX_KW_LEN = 14;
   localparam int KW_COUNT   = 12;
   localparam int HIST_DEPTH = MAX_KW_LEN - 1;

   typedef logic [7:0]                  byte_type;
   typedef logic [MAX_KW_LEN-1:0][7:0]  window_type;
   typedef logic [HIST_DEPTH-1:0][7:0]  history_type;

   // Keyword lengths in bytes.
   localparam logic [4:0] KW_LEN [KW_COUNT] = '{
      5'd8, 5'd9, 5'd9, 5'd6, 5'd7, 5'd4, 5'd4, 5'd6, 5'd8, 5'd4, 5'd4, 5'd14
   };

   // Keywords stored last byte first, so entry j lines up with window byte j
   // (window byte 0 is the newest). Unused positions are zero.
   localparam logic [7:0] KW_REV [KW_COUNT][MAX_KW_LEN] = '{
      '{8'h68, 8'h63, 8'h74, 8'h61, 8'h70, 8'h6c, 8'h61, 8'h74,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h68, 8'h63, 8'h74, 8'h61, 8'h70, 8'h5f, 8'h6c, 8'h61,
        8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h68, 8'h63, 8'h74, 8'h61, 8'h70, 8'h2d, 8'h6c, 8'h61,
        8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6b, 8'h73, 8'h69, 8'h67, 8'h79, 8'h7a, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h64, 8'h65, 8'h73, 8'h6f, 8'h70, 8'h73, 8'h6c, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h64, 8'h70, 8'h73, 8'h6c, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h75, 8'h72, 8'h69, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6b, 8'h73, 8'h69, 8'h67, 8'h61, 8'h6d, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h75, 8'h73, 8'h6c, 8'h65, 8'h6e, 8'h72, 8'h65, 8'h6b,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h75, 8'h73, 8'h6b, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h64, 8'h75, 8'h73, 8'h6b, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6f, 8'h73, 8'h2e, 8'h68, 8'h63, 8'h74, 8'h61, 8'h70,
        8'h6c, 8'h61, 8'h74, 8'h62, 8'h69, 8'h6c}
   };

   // Folds an upper-case ASCII letter to lower case; other bytes pass.
   function automatic byte_type fold_case(input byte_type c);
      byte_type r;
      r = c;
      if (c inside {[8'h41:8'h5A]}) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

[sv/klf_channels.sv]
// Channel interfaces for the keyword line filter: input bytes, verdicts
// and the filter enable register write. Depends on klf_pkg for types.
interface klf_req_if;
   logic                valid;
   logic                ready;
   klf_pkg::byte_type   char_in;
   logic                line_end;
   modport source (output valid, char_in, line_end, input ready);
   modport sink   (input valid, char_in, line_end, output ready);
endinterface

interface klf_rsp_if;
   logic valid;
   logic ready;
   logic drop_line;
   modport source (output valid, drop_line, input ready);
   modport sink   (input valid, drop_line, output ready);
endinterface

interface klf_csr_if;
   logic valid;
   logic ready;
   logic filter_enable;
   modport source (output valid, filter_enable, input ready);
   modport sink   (input valid, filter_enable, output ready);
endinterface

[sv/keyword_line_filter.sv]
// Keyword line filter: one byte per item in, one drop verdict per line out.
// The verdict of a line passes the input register, then the compare and result
// register, after its last byte is accepted. One byte item per cycle, set by
// the single-pass compare, unless a last byte waits behind a stalled verdict.
// Reset (synchronous, active high) empties both stages, clears the history
// and flags, and sets filter_enable to 1.
module keyword_line_filter (
   input  logic         clock,
   input  logic         reset,
   klf_req_if.sink      req_ch,
   klf_rsp_if.source    rsp_ch,
   klf_csr_if.sink      csr_ch
);

   // Input register stage.
   logic                 s1_valid_ff, s1_valid_in;
   klf_pkg::byte_type    s1_char_ff, s1_char_in;
   logic                 s1_last_ff, s1_last_in;

   // Line state.
   klf_pkg::history_type history_ff, history_in;
   logic                 match_ff, match_in;
   logic                 zero_seen_ff, zero_seen_in;
   logic                 enable_ff, enable_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 drop_ff, drop_in;

   klf_pkg::window_type  window;
   logic                 hit;
   logic                 fire;
   logic                 req_accept;
   logic                 byte_live;
   logic                 line_match;

   // The staged item moves on unless it carries a verdict and the result
   // register is full and stalled.
   assign fire       = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || fire;
   assign req_accept = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign window = {history_ff, klf_pkg::fold_case(s1_char_ff)};

   klf_match u_match (
      .window (window),
      .hit    (hit)
   );

   assign byte_live  = !zero_seen_ff && (s1_char_ff != 8'h00);
   assign line_match = match_ff || (byte_live && hit);

   // Input stage next state.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_char_in  = s1_char_ff;
      s1_last_in  = s1_last_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_char_in  = req_ch.char_in;
         s1_last_in  = req_ch.line_end;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // History and flags: a live byte shifts in, a zero byte stops the line,
   // and the last byte clears everything for the next line.
   always_comb begin
      history_in   = history_ff;
      match_in     = match_ff;
      zero_seen_in = zero_seen_ff;
      if (fire) begin
         if (s1_last_ff) begin
            history_in   = '0;
            match_in     = 1'b0;
            zero_seen_in = 1'b0;
         end else if (byte_live) begin
            history_in = window[klf_pkg::HIST_DEPTH-1:0];
            match_in   = line_match;
         end else if (!zero_seen_ff) begin
            zero_seen_in = 1'b1;
         end
      end
   end

   // Result register, loaded on the last byte of a line.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      drop_in      = drop_ff;
      if (fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         drop_in      = line_match && enable_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Enable register write.
   always_comb begin
      enable_in = enable_ff;
      if (csr_ch.valid) begin
         enable_in = csr_ch.filter_enable;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         history_ff   <= '0;
         match_ff     <= 1'b0;
         zero_seen_ff <= 1'b0;
         enable_ff    <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         history_ff   <= history_in;
         match_ff     <= match_in;
         zero_seen_ff <= zero_seen_in;
         enable_ff    <= enable_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_char_ff <= s1_char_in;
      s1_last_ff <= s1_last_in;
      drop_ff    <= drop_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.drop_line = drop_ff;

endmodule

[sv/klf_match.sv]
// Parallel keyword comparator for the keyword line filter.
// Depends on klf_pkg for the keyword tables and the window type.
module klf_match (
   input  klf_pkg::window_type window,
   output logic                hit
);

   logic [klf_pkg::KW_COUNT-1:0] kw_hit;

   // Each keyword compares its bytes against the newest window bytes.
   always_comb begin
      for (int k = 0; k < klf_pkg::KW_COUNT; k++) begin
         kw_hit[k] = 1'b1;
         for (int j = 0; j < klf_pkg::MAX_KW_LEN; j++) begin
            if ((j < int'(klf_pkg::KW_LEN[k])) &&
                (window[j] != klf_pkg::KW_REV[k][j])) begin
               kw_hit[k] = 1'b0;
            end
         end
      end
   end

   assign hit = |kw_hit;

endmodule

[sv/klf_checker.sv]
// Port-level checker for the keyword line filter, bound to the top level.
// Depends only on the top level's channel signals.
module klf_assertions (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_line_end,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_drop_line,
   input logic csr_valid,
   input logic csr_ready,
   input logic csr_filter_enable
);

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       enable_ff;
   logic       enable_in;
   logic       line_in;
   logic       line_out;

   // Lines accepted whose verdict is not yet taken.
   assign line_in  = req_valid && req_ready && req_line_end;
   assign line_out = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (line_in && !line_out && (pending_ff != 2'd3)) begin
         pending_in = pending_ff + 2'd1;
      end else if (!line_in && line_out && (pending_ff != 2'd0)) begin
         pending_in = pending_ff - 2'd1;
      end
      enable_in = enable_ff;
      if (csr_valid && csr_ready) begin
         enable_in = csr_filter_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         enable_ff  <= 1'b1;
      end else begin
         pending_ff <= pending_in;
         enable_ff  <= enable_in;
      end
   end

   // A stalled verdict stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("verdict withdrawn while stalled");

   // A stalled verdict keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_drop_line))
      else $error("verdict changed while stalled");

   // No verdict without a finished line, and at most two lines in flight.
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || (pending_ff != 2'd0)) && (pending_ff != 2'd3))
      else $error("verdict count does not match finished lines");

   // With the filter disabled no line is dropped.
   a_disabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !enable_ff |-> !rsp_drop_line)
      else $error("line dropped with filter disabled");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("verdict offered right after reset");

endmodule

bind keyword_line_filter klf_assertions u_klf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_line_end      (req_ch.line_end),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_drop_line     (rsp_ch.drop_line),
   .csr_valid         (csr_ch.valid),
   .csr_ready         (csr_ch.ready),
   .csr_filter_enable (csr_ch.filter_enable)
);

[tb/klf_tb_pkg.sv]
// Keyword table shared by the stimulus and the checker of the keyword line filter.
// Keywords are stored first byte first and padded with zeros; no dependencies.
package klf_tb_pkg;

   localparam int KEYS    = 12;
   localparam int KEY_MAX = 14;

   // Length of each keyword in bytes.
   localparam int KEY_LEN [KEYS] = '{8, 9, 9, 6, 7, 4, 4, 6, 8, 4, 4, 14};

   // Keyword text in reading order, lower case.
   localparam logic [7:0] KEY_TEXT [KEYS][KEY_MAX] = '{
      '{8'h74, 8'h61, 8'h6c, 8'h70, 8'h61, 8'h74, 8'h63, 8'h68,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h74, 8'h61, 8'h6c, 8'h5f, 8'h70, 8'h61, 8'h74, 8'h63,
        8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h74, 8'h61, 8'h6c, 8'h2d, 8'h70, 8'h61, 8'h74, 8'h63,
        8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h7a, 8'h79, 8'h67, 8'h69, 8'h73, 8'h6b, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6c, 8'h73, 8'h70, 8'h6f, 8'h73, 8'h65, 8'h64, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6c, 8'h73, 8'h70, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h69, 8'h72, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6d, 8'h61, 8'h67, 8'h69, 8'h73, 8'h6b, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6b, 8'h65, 8'h72, 8'h6e, 8'h65, 8'h6c, 8'h73, 8'h75,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h2f, 8'h6b, 8'h73, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6b, 8'h73, 8'h75, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6c, 8'h69, 8'h62, 8'h74, 8'h61, 8'h6c, 8'h70, 8'h61,
        8'h74, 8'h63, 8'h68, 8'h2e, 8'h73, 8'h6f}
   };

endpackage

[tb/klf_checker.sv]
// Checker for the keyword line filter: watches the byte, verdict and enable channels,
// predicts the drop verdict of every finished line and compares it with the block.
// Depends on klf_pkg, klf_tb_pkg and the channel interfaces.
module klf_checker (
   input  logic clock,
   input  logic reset,
   klf_req_if   req_ch,
   klf_rsp_if   rsp_ch,
   klf_csr_if   csr_ch,
   output int   fail_count,
   output int   pending_lines
);

   import klf_tb_pkg::*;

   typedef klf_pkg::byte_type byte_t;

   byte_t hist [KEY_MAX-1];   // hist[0] is the newest folded byte
   bit    key_hit;
   bit    nul_seen;
   bit    enable_q;
   bit    drop_queue [$];
   int    errors = 0;
   int    lines_checked = 0;
   int    pend = 0;

   assign fail_count    = errors;
   assign pending_lines = pend;

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string msg);
      $display("klf_checker: line %0d: %s", lines_checked, msg);
      errors++;
   endtask

   // Only upper-case ASCII letters change.
   function automatic byte_t lower_byte(input byte_t c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // Clears the history and the flags at the start of a line.
   task automatic clear_line();
      int j;
      for (j = 0; j < KEY_MAX - 1; j++) begin
         hist[j] = 8'h00;
      end
      key_hit  = 1'b0;
      nul_seen = 1'b0;
   endtask

   // Shifts one byte into the history, looks for a keyword ending at it, and
   // queues the verdict when the byte closes the line.
   task automatic predict_byte(input byte_t c, input bit last);
      byte_t win [KEY_MAX];
      bit    hit;
      int    j;
      int    k;
      int    n;
      if (!nul_seen) begin
         if (c == 8'h00) begin
            nul_seen = 1'b1;
         end else begin
            win[0] = lower_byte(c);
            for (j = 1; j < KEY_MAX; j++) begin
               win[j] = hist[j-1];
            end
            for (k = 0; k < KEYS; k++) begin
               n   = KEY_LEN[k];
               hit = 1'b1;
               for (j = 0; j < n; j++) begin
                  if (win[n-1-j] != KEY_TEXT[k][j]) begin
                     hit = 1'b0;
                  end
               end
               if (hit) begin
                  key_hit = 1'b1;
               end
            end
            for (j = 0; j < KEY_MAX - 1; j++) begin
               hist[j] = win[j];
            end
         end
      end
      if (last) begin
         drop_queue.push_back(key_hit && enable_q);
         clear_line();
      end
   endtask

   // Samples all three channels at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_line();
         enable_q = 1'b1;
         drop_queue.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (drop_queue.size() == 0) begin
               report_mismatch("verdict with no finished line waiting");
            end else begin
               if (rsp_ch.drop_line !== drop_queue[0]) begin
                  report_mismatch($sformatf("drop_line %b, predicted %b",
                                            rsp_ch.drop_line, drop_queue[0]));
               end
               void'(drop_queue.pop_front());
            end
            lines_checked++;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            enable_q = csr_ch.filter_enable;
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_byte(req_ch.char_in, req_ch.line_end);
         end
      end
      pend = drop_queue.size();
   end

endmodule

[tb/tb.sv]
// Top of the keyword line filter testbench: clock, reset, byte and enable stimulus,
// receiver stalls and the verdict. Depends on klf_pkg, klf_tb_pkg, the channel
// interfaces, klf_checker and keyword_line_filter.
module tb;

   import klf_tb_pkg::*;

   typedef klf_pkg::byte_type byte_t;

   localparam int RESET_CYCLES   = 11;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 180;
   localparam int PRESSURE_PHASE = 4;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 6;
   localparam int DRAIN_CYCLES   = 20;
   localparam int CYCLE_LIMIT    = 200000;

   // Idling per mode: none, sender only, receiver only, both.
   localparam int SEND_IDLE [4] = '{0, 53, 0, 35};
   localparam int RECV_IDLE [4] = '{0, 0, 53, 35};
   localparam bit PHASE_ENABLE [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

   logic clock;
   logic reset;

   klf_req_if req_ch ();
   klf_rsp_if rsp_ch ();
   klf_csr_if csr_ch ();

   int    fail_count;
   int    pending_lines;
   int    cycle_count = 0;
   int    idle_pct = 0;
   int    stall_pct;
   bit    long_hold_req;
   int    items_sent;
   byte_t line_buf [$];

   keyword_line_filter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   klf_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_lines (pending_lines)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Verdict receiver: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_used) begin
            hold_left = LONG_HOLD;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Upper-cases a lower-case letter at random; other bytes pass.
   function automatic byte_t mix_case(input byte_t b);
      if (b >= 8'h61 && b <= 8'h7A && $urandom_range(1) == 1) begin
         return b - 8'h20;
      end
      return b;
   endfunction

   // Mostly letters of the keywords, so that partial matches are common.
   function automatic byte_t filler_byte();
      int    k;
      int    sel;
      byte_t b;
      k   = $urandom_range(KEYS - 1);
      sel = $urandom_range(99);
      if (sel < 50) begin
         b = mix_case(KEY_TEXT[k][$urandom_range(KEY_LEN[k] - 1)]);
      end else if (sel < 80) begin
         b = mix_case(byte_t'(8'h61 + $urandom_range(25)));
      end else begin
         b = byte_t'($urandom_range(255, 1));
      end
      return b;
   endfunction

   task automatic add_filler();
      int n;
      n = ($urandom_range(99) < 5) ? $urandom_range(40) : $urandom_range(6);
      repeat (n) line_buf.push_back(filler_byte());
   endtask

   // Builds one line: mostly keywords, whole or broken, in filler; some pure noise.
   task automatic build_line();
      int kind;
      int k;
      int i;
      int cut;
      int spot;
      int mode;
      line_buf.delete();
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(24, 1)) line_buf.push_back(byte_t'($urandom_range(255)));
      end else begin
         add_filler();
         k = $urandom_range(KEYS - 1);
         if (kind < 65) begin
            for (i = 0; i < KEY_LEN[k]; i++) begin
               line_buf.push_back(mix_case(KEY_TEXT[k][i]));
            end
         end else if (kind < 85) begin
            // A near miss: cut short, one byte replaced, or one byte inserted.
            mode = $urandom_range(2);
            cut  = $urandom_range(KEY_LEN[k] - 1, 1);
            spot = $urandom_range(KEY_LEN[k] - 1);
            for (i = 0; i < KEY_LEN[k]; i++) begin
               if (mode == 0 && i >= cut) begin
                  break;
               end
               if (mode == 2 && i == spot) begin
                  line_buf.push_back(filler_byte());
               end
               if (mode == 1 && i == spot) begin
                  line_buf.push_back(filler_byte());
               end else begin
                  line_buf.push_back(mix_case(KEY_TEXT[k][i]));
               end
            end
         end
         add_filler();
         if ($urandom_range(99) < 12) begin
            line_buf.insert($urandom_range(line_buf.size()), 8'h00);
         end
      end
      if (line_buf.size() == 0) begin
         line_buf.push_back(filler_byte());
      end
   endtask

   // Offers one byte item and waits until it is taken.
   task automatic send_item(input byte_t c, input bit last);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.char_in  <= c;
      req_ch.line_end <= last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
   endtask

   // Sends the line buffer; bytes after a zero byte, but for the last, do not count as work.
   task automatic send_line();
      int i;
      bit after_zero;
      after_zero = 1'b0;
      for (i = 0; i < line_buf.size(); i++) begin
         send_item(line_buf[i], i == line_buf.size() - 1);
         if (!after_zero || i == line_buf.size() - 1) begin
            items_sent++;
         end
         if (line_buf[i] == 8'h00) begin
            after_zero = 1'b1;
         end
      end
   endtask

   // Waits until every verdict is back and the block has settled.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_lines != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input bit value);
      csr_ch.valid         <= 1'b1;
      csr_ch.filter_enable <= value;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Main stimulus: reset, directed lines, then random phases.
   initial begin
      int phase;
      int mode;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.char_in       <= 8'h00;
      req_ch.line_end      <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.filter_enable <= 1'b0;
      stall_pct            <= 0;
      long_hold_req        <= 1'b0;
      items_sent = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed lines with the filter enabled from reset.
      // A line that is only a zero byte.
      line_buf = '{8'h00};
      send_line();
      // A keyword in upper case.
      line_buf = '{8'h52, 8'h49, 8'h52, 8'h55};
      send_line();
      // A keyword before a zero byte still counts; the byte after it is ignored.
      line_buf = '{8'h6c, 8'h73, 8'h70, 8'h64, 8'h00, 8'hff};
      send_line();
      // A keyword after a zero byte is ignored.
      line_buf = '{8'h00, 8'h72, 8'h69, 8'h72, 8'h75};
      send_line();
      // A keyword split across two lines must not match.
      line_buf = '{8'h72, 8'h69};
      send_line();
      line_buf = '{8'h72, 8'h75};
      send_line();
      // The largest byte value alone.
      line_buf = '{8'hff};
      send_line();
      wait_drained();

      // Random phases under each idling mode, with the filter enabled or disabled per phase.
      for (phase = 0; phase < PHASES; phase++) begin
         mode = phase % 4;
         idle_pct = SEND_IDLE[mode];
         stall_pct <= RECV_IDLE[mode];
         write_enable(PHASE_ENABLE[phase]);
         if (phase == PRESSURE_PHASE) begin
            long_hold_req <= 1'b1;
         end
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) begin
            build_line();
            send_line();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

[keyword_line_filter.f]
sv/klf_pkg.sv
sv/klf_channels.sv
sv/klf_match.sv
sv/keyword_line_filter.sv
sv/klf_checker.sv
tb/klf_tb_pkg.sv
tb/klf_checker.sv
tb/tb.sv
